/* rtl/lfu_pkg.sv */
package lfu_pkg;

  localparam int Entries    = 16;
  localparam int SlotBits   = 4;
  localparam int HeldBits   = 5;
  localparam int KeyBits    = 32;
  localparam int ValueBits  = 32;
  localparam int UsesBits   = 32;
  localparam int MaxResults = 16;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_TOPK   = 2'd2,
    KIND_SHRINK = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_MISS     = 3'd3,
    ST_LISTED   = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  // scan mode of the datapath
  typedef enum logic [1:0] {
    SCAN_FIND   = 2'd0,
    SCAN_VICTIM = 2'd1,
    SCAN_BEST   = 2'd2
  } scan_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_DECIDE,
    S_VICTIM,
    S_EVICT,
    S_INSERT,
    S_BEST,
    S_BEST_EMIT,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic    load;        // latch input item
    logic    scan_start;  // clear scan, slot 0
    logic    scan_step;   // evaluate slot, advance
    scan_t   scan_mode;
    logic    update_hit;  // put/get hit update
    logic    remove_best; // remove scan winner (victim)
    logic    insert;      // insert latched key into free slot
    logic    take_best;   // mark scan winner as listed
    logic    out_load;    // load output register
    status_t out_status;
    logic    out_from_best; // fields from scan winner
    logic    out_last;
  } lfu_cmd_t;

  typedef struct packed {
    logic        scan_done;
    logic        found;     // scan produced a match/winner
    logic [1:0]  kind;
    logic        need_evict;
    logic        over_cap;
    logic        fit_after; // store fits capacity once one entry is removed
    logic        out_busy;
    logic [HeldBits-1:0] held;
    logic [HeldBits-1:0] want;
  } lfu_stat_t;

endpackage

/* rtl/lfu_datapath.sv */
module lfu_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  lfu_pkg::lfu_cmd_t         cmd,
  output lfu_pkg::lfu_stat_t        stat,
  input  logic [1:0]                in_kind,
  input  logic [lfu_pkg::KeyBits-1:0]   in_key,
  input  logic [lfu_pkg::ValueBits-1:0] in_value,
  input  logic [4:0]                in_count,
  input  logic                      cfg_valid,
  input  logic [4:0]                cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [31:0]               out_key,
  output logic [31:0]               out_value,
  output logic [31:0]               frequency,
  output logic                      last
);
  localparam int N = lfu_pkg::Entries;
  localparam int SB = lfu_pkg::SlotBits;
  localparam int HB = lfu_pkg::HeldBits;

  logic [N-1:0]                   vld;
  logic [N-1:0]                   taken;
  logic [lfu_pkg::KeyBits-1:0]    ekey [N];
  logic [lfu_pkg::ValueBits-1:0]  eval [N];
  logic [lfu_pkg::UsesBits-1:0]   euse [N];
  logic [HB-1:0]                  eage [N];
  logic [HB-1:0]                  held;
  logic [4:0]                     cap_reg;

  logic [1:0]                     kind;
  logic [lfu_pkg::KeyBits-1:0]    key;
  logic [lfu_pkg::ValueBits-1:0]  value;
  logic [HB-1:0]                  want;

  logic [HB-1:0]                  scan;
  logic                           found;
  logic [SB-1:0]                  best;

  logic [SB-1:0]                  cur;
  logic [HB-1:0]                  cap;
  logic                           better;
  logic [SB-1:0]                  free_slot;
  logic [lfu_pkg::UsesBits-1:0]   bumped;

  assign cur = scan[SB-1:0];
  assign cap = (cap_reg == 5'd0) ? HB'(1) :
               (cap_reg > 5'(N)) ? HB'(N) : HB'(cap_reg);
  assign bumped = (euse[best] == '1) ? euse[best] : euse[best] + 1'b1;

  always_comb begin
    better = 1'b0;
    case (cmd.scan_mode)
      lfu_pkg::SCAN_FIND:
        better = !found && vld[cur] && ekey[cur] == key;
      lfu_pkg::SCAN_VICTIM:
        better = vld[cur] && (!found || euse[cur] < euse[best] ||
                 (euse[cur] == euse[best] && eage[cur] < eage[best]));
      lfu_pkg::SCAN_BEST:
        better = vld[cur] && !taken[cur] && (!found || euse[cur] > euse[best] ||
                 (euse[cur] == euse[best] && (eval[cur] < eval[best] ||
                 (eval[cur] == eval[best] && ekey[cur] < ekey[best]))));
      default: better = 1'b0;
    endcase
  end

  always_comb begin
    free_slot = '0;
    for (int s = N - 1; s >= 0; s--) begin
      if (!vld[s]) free_slot = SB'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      taken   <= '0;
      held    <= '0;
      cap_reg <= 5'd16;
      scan    <= '0;
      found   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) cap_reg <= cfg_data;
      if (cmd.load) begin
        kind  <= in_kind;
        key   <= in_key;
        value <= in_value;
        want  <= in_count;
        taken <= '0;
      end
      if (cmd.scan_start) begin
        scan  <= '0;
        found <= 1'b0;
      end else if (cmd.scan_step) begin
        scan <= scan + 1'b1;
        if (better) begin
          found <= 1'b1;
          best  <= cur;
        end
      end
      if (cmd.update_hit) begin
        if (kind == lfu_pkg::KIND_PUT) eval[best] <= value;
        euse[best] <= bumped;
      end
      if (cmd.take_best) taken[best] <= 1'b1;
      if (cmd.remove_best) begin
        for (int s = 0; s < N; s++) begin
          if (vld[s] && SB'(s) != best && eage[s] > eage[best])
            eage[s] <= eage[s] - 1'b1;
        end
        vld[best] <= 1'b0;
        held <= held - 1'b1;
      end
      if (cmd.insert && held < HB'(N)) begin
        vld[free_slot]  <= 1'b1;
        ekey[free_slot] <= key;
        eval[free_slot] <= value;
        euse[free_slot] <= 32'd1;
        eage[free_slot] <= held;
        held <= held + 1'b1;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        status    <= cmd.out_status;
        last      <= cmd.out_last;
        if (cmd.out_status == lfu_pkg::ST_HIT) begin
          out_key   <= key;
          out_value <= (kind == lfu_pkg::KIND_PUT) ? value : eval[best];
          frequency <= bumped;
        end else if (cmd.out_status == lfu_pkg::ST_INSERTED) begin
          out_key   <= key;
          out_value <= value;
          frequency <= 32'd1;
        end else if (cmd.out_status == lfu_pkg::ST_MISS) begin
          out_key   <= key;
          out_value <= '0;
          frequency <= '0;
        end else if (cmd.out_from_best) begin
          out_key   <= ekey[best];
          out_value <= eval[best];
          frequency <= euse[best];
        end else begin
          out_key   <= '0;
          out_value <= '0;
          frequency <= '0;
        end
      end
    end
  end

  assign stat.scan_done  = cmd.scan_step && scan == HB'(N - 1);
  assign stat.found      = found;
  assign stat.kind       = kind;
  assign stat.need_evict = held >= cap;
  assign stat.over_cap   = held > cap;
  assign stat.fit_after  = held <= cap + HB'(1);
  assign stat.out_busy   = out_valid && !out_ready;
  assign stat.held       = held;
  assign stat.want       = (want > held) ? held : want;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HB'(N)) else $error("held overflow");
  a_held_count: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(held)) else $error("held mismatch");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy) else $error("output overwritten");
`endif
endmodule

/* rtl/lfu_ctrl.sv */
module lfu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lfu_pkg::lfu_stat_t  stat,
  output lfu_pkg::lfu_cmd_t   cmd
);
  lfu_pkg::state_t state, state_next;
  logic [4:0] n, n_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::S_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
    end
  end

  always_comb begin
    state_next = state;
    n_next     = n;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lfu_pkg::S_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && in_ready) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          n_next         = '0;
          state_next     = lfu_pkg::S_FIND;
        end
      end
      lfu_pkg::S_FIND: begin
        cmd.scan_mode = lfu_pkg::SCAN_FIND;
        if (stat.kind == lfu_pkg::KIND_TOPK) begin
          if (stat.want == '0) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = lfu_pkg::ST_EMPTY;
            cmd.out_last   = 1'b1;
            state_next     = lfu_pkg::S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = lfu_pkg::S_BEST;
          end
        end else if (stat.kind == lfu_pkg::KIND_SHRINK) begin
          cmd.scan_start = 1'b1;
          state_next     = lfu_pkg::S_VICTIM;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.scan_done) state_next = lfu_pkg::S_DECIDE;
        end
      end
      lfu_pkg::S_DECIDE: begin
        // output register is free here: nothing was loaded since the item was taken
        if (stat.found) begin
          cmd.update_hit = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = lfu_pkg::ST_HIT;
          cmd.out_last   = 1'b1;
          state_next     = lfu_pkg::S_IDLE;
        end else if (stat.kind == lfu_pkg::KIND_GET) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = lfu_pkg::ST_MISS;
          cmd.out_last   = 1'b1;
          state_next     = lfu_pkg::S_IDLE;
        end else if (stat.need_evict) begin
          cmd.scan_start = 1'b1;
          state_next     = lfu_pkg::S_VICTIM;
        end else begin
          cmd.insert     = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = lfu_pkg::ST_INSERTED;
          cmd.out_last   = 1'b1;
          state_next     = lfu_pkg::S_IDLE;
        end
      end
      lfu_pkg::S_VICTIM: begin
        cmd.scan_mode = lfu_pkg::SCAN_VICTIM;
        if (stat.kind == lfu_pkg::KIND_SHRINK && n == 5'(lfu_pkg::MaxResults)) begin
          state_next = lfu_pkg::S_IDLE;
        end else if (stat.kind == lfu_pkg::KIND_SHRINK && !stat.over_cap) begin
          if (n == '0) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = lfu_pkg::ST_EMPTY;
            cmd.out_last   = 1'b1;
            state_next     = lfu_pkg::S_IDLE;
          end else begin
            state_next = lfu_pkg::S_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.scan_done) state_next = lfu_pkg::S_EVICT;
        end
      end
      lfu_pkg::S_EVICT: begin
        // output register must be free before the victim fields are copied
        if (!stat.out_busy) begin
          cmd.out_load      = 1'b1;
          cmd.out_from_best = 1'b1;
          cmd.remove_best   = 1'b1;
          if (stat.kind == lfu_pkg::KIND_PUT) begin
            cmd.out_status = lfu_pkg::ST_EVICTED;
            cmd.out_last   = 1'b1;
            state_next     = lfu_pkg::S_INSERT;
          end else begin
            cmd.out_status = lfu_pkg::ST_LISTED;
            n_next         = n + 1'b1;
            // last evict when store fits after this or limit reached
            cmd.out_last   = stat.fit_after ||
                             (n + 1'b1 == 5'(lfu_pkg::MaxResults));
            state_next     = lfu_pkg::S_WAIT;
          end
        end
      end
      lfu_pkg::S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = lfu_pkg::S_IDLE;
      end
      lfu_pkg::S_BEST: begin
        cmd.scan_mode = lfu_pkg::SCAN_BEST;
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = lfu_pkg::S_BEST_EMIT;
      end
      lfu_pkg::S_BEST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.out_load      = 1'b1;
          cmd.out_from_best = 1'b1;
          cmd.out_status    = lfu_pkg::ST_LISTED;
          cmd.take_best     = 1'b1;
          n_next            = n + 1'b1;
          cmd.out_last      = (n + 1'b1 == stat.want);
          if (n + 1'b1 == stat.want) begin
            state_next = lfu_pkg::S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = lfu_pkg::S_BEST;
          end
        end
      end
      lfu_pkg::S_WAIT: begin
        cmd.scan_start = 1'b1;
        state_next     = lfu_pkg::S_VICTIM;
      end
      default: state_next = lfu_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == lfu_pkg::S_IDLE) else $error("ready outside idle");
  a_one_remove: assert property (@(posedge clk) disable iff (rst)
    cmd.remove_best |-> !cmd.insert) else $error("remove with insert");
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == lfu_pkg::S_FIND) else $error("bad start");
`endif
endmodule

/* rtl/lfu_cache_with_top_k_top.sv */
// LFU key/value store with top-k listing.
// Input channel (in_valid/in_ready): kind, key, value, count. One item is
// taken at a time; in_ready is high only while the controller is idle and
// the output register is free.
// Output channel (out_valid/out_ready): status, out_key, out_value,
// frequency, last. last marks the final result of an item.
// Config channel (cfg_valid/cfg_ready): capacity_limit, write when idle.
// The scan visits one slot per clock. A put or get scans the store once and
// then returns its result; a put that evicts scans twice, once for the key
// and once for the victim. Top k scans once per listed entry; shrink scans
// once per eviction and lists at most 16 evictions. An empty top k or
// shrink returns a single empty result.
// Items are handled strictly one after another.
// Reset empties the store and sets capacity to 16.
// A stalled receiver holds the block at the next result until taken.
module lfu_cache_with_top_k_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] key,
  input  logic [31:0] value,
  input  logic [4:0]  count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] out_key,
  output logic [31:0] out_value,
  output logic [31:0] frequency,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  capacity_limit
);
  lfu_pkg::lfu_cmd_t  cmd;
  lfu_pkg::lfu_stat_t stat;

  assign cfg_ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  lfu_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_kind(kind), .in_key(key), .in_value(value), .in_count(count),
    .cfg_valid(cfg_valid), .cfg_data(capacity_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_key(out_key), .out_value(out_value),
    .frequency(frequency), .last(last)
  );
endmodule

/* tb/lfu_cache_with_top_k_checker.sv */
`timescale 1ns / 100ps
module lfu_cache_with_top_k_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] key,
  input  logic [31:0] value,
  input  logic [4:0]  count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [31:0] out_key,
  input  logic [31:0] out_value,
  input  logic [31:0] frequency,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  capacity_limit,
  output int          errors,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    lfu_pkg::status_t st;
    logic [31:0]      k;
    logic [31:0]      v;
    logic [31:0]      f;
    logic             lst;
  } lfu_result_t;

  lfu_result_t expected_q[$];

  logic [4:0]  cap_reg;
  logic        slot_used[lfu_pkg::Entries];
  logic [31:0] slot_key[lfu_pkg::Entries];
  logic [31:0] slot_val[lfu_pkg::Entries];
  logic [31:0] slot_uses[lfu_pkg::Entries];
  logic [4:0]  slot_age[lfu_pkg::Entries];
  logic [4:0]  held;

  function automatic lfu_result_t mk(lfu_pkg::status_t st, logic [31:0] k,
                                     logic [31:0] v, logic [31:0] f);
    lfu_result_t r;
    r.st = st; r.k = k; r.v = v; r.f = f; r.lst = 1'b0;
    return r;
  endfunction

  function automatic int least_used_slot();
    int b;
    b = -1;
    for (int s = 0; s < lfu_pkg::Entries; s++) begin
      if (!slot_used[s]) continue;
      if (b < 0 || slot_uses[s] < slot_uses[b] ||
          (slot_uses[s] == slot_uses[b] && slot_age[s] < slot_age[b]))
        b = s;
    end
    return b;
  endfunction

  function automatic void drop_slot(int d);
    for (int s = 0; s < lfu_pkg::Entries; s++)
      if (slot_used[s] && s != d && slot_age[s] > slot_age[d]) slot_age[s]--;
    slot_used[d] = 1'b0;
    if (held > 0) held--;
  endfunction

  function automatic logic [31:0] bumped(logic [31:0] u);
    return (u == 32'hFFFF_FFFF) ? u : u + 1;
  endfunction

  function automatic int lookup(logic [31:0] k);
    for (int s = 0; s < lfu_pkg::Entries; s++)
      if (slot_used[s] && slot_key[s] == k) return s;
    return -1;
  endfunction

  task automatic predict_transaction(lfu_pkg::kind_t op, logic [31:0] k,
                                     logic [31:0] v, logic [4:0] want_in);
    lfu_result_t res[$];
    int cap, s, vic, b, want;
    logic taken[lfu_pkg::Entries];
    lfu_result_t ev;
    cap = (cap_reg == 0) ? 1 :
          (cap_reg > lfu_pkg::Entries ? lfu_pkg::Entries : cap_reg);
    case (op)
      lfu_pkg::KIND_PUT: begin
        s = lookup(k);
        if (s >= 0) begin
          slot_val[s] = v;
          slot_uses[s] = bumped(slot_uses[s]);
          res.insert(res.size(), mk(lfu_pkg::ST_HIT, k, v, slot_uses[s]));
        end else begin
          vic = -1;
          if (held >= cap) begin
            vic = least_used_slot();
            if (vic >= 0) begin
              ev = mk(lfu_pkg::ST_EVICTED, slot_key[vic], slot_val[vic],
                      slot_uses[vic]);
              drop_slot(vic);
            end
          end
          for (s = 0; s < lfu_pkg::Entries && slot_used[s]; s++) ;
          if (s < lfu_pkg::Entries) begin
            slot_used[s] = 1'b1; slot_key[s] = k; slot_val[s] = v;
            slot_uses[s] = 1; slot_age[s] = held; held++;
          end
          if (vic >= 0) res.insert(res.size(), ev);
          else res.insert(res.size(), mk(lfu_pkg::ST_INSERTED, k, v, 1));
        end
      end
      lfu_pkg::KIND_GET: begin
        s = lookup(k);
        if (s >= 0) begin
          slot_uses[s] = bumped(slot_uses[s]);
          res.insert(res.size(), mk(lfu_pkg::ST_HIT, k, slot_val[s], slot_uses[s]));
        end else res.insert(res.size(), mk(lfu_pkg::ST_MISS, k, 0, 0));
      end
      lfu_pkg::KIND_TOPK: begin
        want = want_in;
        if (want > held) want = held;
        if (want > lfu_pkg::MaxResults) want = lfu_pkg::MaxResults;
        for (int i = 0; i < lfu_pkg::Entries; i++) taken[i] = 1'b0;
        for (int i = 0; i < want; i++) begin
          b = -1;
          for (s = 0; s < lfu_pkg::Entries; s++) begin
            if (!slot_used[s] || taken[s]) continue;
            if (b < 0 || slot_uses[s] > slot_uses[b] ||
                (slot_uses[s] == slot_uses[b] &&
                 (slot_val[s] < slot_val[b] ||
                  (slot_val[s] == slot_val[b] && slot_key[s] < slot_key[b]))))
              b = s;
          end
          if (b < 0) break;
          taken[b] = 1'b1;
          res.insert(res.size(), mk(lfu_pkg::ST_LISTED, slot_key[b], slot_val[b],
                                    slot_uses[b]));
        end
        if (res.size() == 0) res.insert(0, mk(lfu_pkg::ST_EMPTY, 0, 0, 0));
      end
      default: begin
        while (held > cap && res.size() < lfu_pkg::MaxResults) begin
          vic = least_used_slot();
          if (vic < 0) break;
          res.insert(res.size(), mk(lfu_pkg::ST_LISTED, slot_key[vic],
                                    slot_val[vic], slot_uses[vic]));
          drop_slot(vic);
        end
        if (res.size() == 0) res.insert(0, mk(lfu_pkg::ST_EMPTY, 0, 0, 0));
      end
    endcase
    res[res.size()-1].lst = 1'b1;
    foreach (res[i]) expected_q.insert(expected_q.size(), res[i]);
  endtask

  always @(posedge clk) begin
    lfu_result_t e;
    if (rst) begin
      cap_reg <= 5'd16;
      held = 0;
      for (int s = 0; s < lfu_pkg::Entries; s++) slot_used[s] = 1'b0;
      errors <= 0;
      results_seen <= 0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg <= capacity_limit;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: status %0d key %h", status, out_key);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (status != e.st || out_key != e.k || out_value != e.v ||
              frequency != e.f || last != e.lst) begin
            if (errors < 10)
              $display({"mismatch: exp st %0d k %h v %h f %0d l %b, ",
                        "got st %0d k %h v %h f %0d l %b"},
                       e.st, e.k, e.v, e.f, e.lst, status, out_key, out_value,
                       frequency, last);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready)
        predict_transaction(lfu_pkg::kind_t'(kind), key, value, count);
      pending <= expected_q.size();
    end
  end

endmodule

/* tb/tb_lfu_cache_with_top_k_top.sv */
`timescale 1ns / 100ps
module tb_lfu_cache_with_top_k_top;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [1:0]  kind;
  logic [31:0] key, value;
  logic [4:0]  count;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic [31:0] out_key, out_value, frequency;
  logic        last;
  logic        cfg_valid, cfg_ready;
  logic [4:0]  capacity_limit;
  int          errors, pending, results_seen;
  int          cycle_count;
  int          ops_done;
  logic        hold_off;

  localparam int CycleLimit = 400000;

  lfu_cache_with_top_k_top dut (.*);

  lfu_cache_with_top_k_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("** lfu_cache_with_top_k_top: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int w;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (out_ready && !out_valid) out_ready <= 1'b1;
      else begin
        w = (cycle_count % 3000 < 600) ? 0 : $urandom_range(0, 4);
        if (out_ready && out_valid) begin
          if (w != 0) begin
            out_ready <= 1'b0;
            repeat (w) @(posedge clk);
            out_ready <= 1'b1;
          end
        end else out_ready <= 1'b1;
      end
    end
  end

  // valid stays high across back-to-back items; drain drops it
  task automatic send_op(lfu_pkg::kind_t k, logic [31:0] ky, logic [31:0] v,
                         logic [4:0] n);
    int gap;
    gap = (cycle_count % 3000 < 600) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; kind <= k; key <= ky; value <= v; count <= n;
    do @(posedge clk); while (!in_ready);
    ops_done++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cap(logic [4:0] c);
    cfg_valid <= 1'b1; capacity_limit <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    // small key pool so puts and gets hit often
    return ($urandom_range(0, 9) == 0) ? $urandom() : 32'h1000 + $urandom_range(0, 23);
  endfunction

  initial begin
    int r;
    rst = 1; in_valid = 0; kind = lfu_pkg::KIND_PUT; key = 0; value = 0; count = 0;
    cfg_valid = 0; capacity_limit = 16; hold_off = 0; ops_done = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty cases, field extremes, each operation
    send_op(lfu_pkg::KIND_TOPK, 0, 0, 5'd5);
    send_op(lfu_pkg::KIND_SHRINK, 0, 0, 5'd0);
    send_op(lfu_pkg::KIND_GET, 32'hFFFF_FFFF, 0, 5'd0);
    send_op(lfu_pkg::KIND_PUT, 32'h0, 32'hFFFF_FFFF, 5'd31);
    send_op(lfu_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'h0, 5'd0);
    send_op(lfu_pkg::KIND_PUT, 32'h0, 32'h5555_AAAA, 5'd0);
    send_op(lfu_pkg::KIND_GET, 32'h0, 32'hFFFF_FFFF, 5'd31);
    send_op(lfu_pkg::KIND_GET, 32'h1234, 0, 5'd0);
    send_op(lfu_pkg::KIND_TOPK, 0, 0, 5'd0);
    send_op(lfu_pkg::KIND_TOPK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    send_op(lfu_pkg::KIND_TOPK, 0, 0, 5'd16);
    for (int i = 0; i < 6; i++) send_op(lfu_pkg::KIND_PUT, 32'h200 + i, 32'h7, 5'd0);
    drain();
    // capacity lowered without shrink: a put evicts just one entry, then shrinks trim the rest
    write_cap(5'd2);
    send_op(lfu_pkg::KIND_PUT, 32'h300, 1, 5'd0);
    send_op(lfu_pkg::KIND_SHRINK, 0, 0, 5'd0);
    send_op(lfu_pkg::KIND_SHRINK, 0, 0, 5'd0);
    drain();
    write_cap(5'd0);
    send_op(lfu_pkg::KIND_PUT, 32'h301, 2, 5'd0);
    send_op(lfu_pkg::KIND_PUT, 32'h302, 3, 5'd0);
    drain();
    write_cap(5'd31);
    drain();

    // random phases with different capacities
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        fork
          begin hold_off = 1; repeat (400) @(posedge clk); hold_off = 0; end
        join_none
      end
      for (int i = 0; i < 40; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45)
          send_op(lfu_pkg::KIND_PUT, pick_key(),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom(),
                  5'($urandom_range(0, 31)));
        else if (r < 75)
          send_op(lfu_pkg::KIND_GET, pick_key(), $urandom(), 5'($urandom_range(0, 31)));
        else if (r < 90)
          send_op(lfu_pkg::KIND_TOPK, $urandom(), $urandom(), 5'($urandom_range(0, 31)));
        else
          send_op(lfu_pkg::KIND_SHRINK, $urandom(), $urandom(), 5'($urandom_range(0, 31)));
      end
      drain();
      write_cap((ph == 4) ? 5'd1 : (ph == 0) ? 5'd16 : 5'($urandom_range(0, 31)));
      drain();
    end

    drain();
    $display("run covered %0d operations and %0d results, capacities 0..31 incl. extremes",
             ops_done, results_seen);
    if (errors == 0 && pending == 0) begin
      $display("** lfu_cache_with_top_k_top: PASSED **");
    end else begin
      $display("mismatches %0d, outstanding %0d", errors, pending);
      $display("** lfu_cache_with_top_k_top: FAILED **");
    end
    $finish;
  end

endmodule
